FILE: hw/rtl/sidu_pkg.sv
`default_nettype none

package sidu_pkg;

  // Width of the value field on the input channel
  localparam int unsigned VALUE_FIELD_W = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Which character the datapath loads into the output register
  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_DIGIT,
    SEL_CR,
    SEL_LF
  } char_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      digit_shift;
    logic      emit;
    char_sel_t sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic neg;
    logic bit_last;
    logic dig_last;
    logic top_zero;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sidu_ifs.sv
`default_nettype none

// Input channel: one signed value per transfer
interface sidu_in_if
  import sidu_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic signed [VALUE_FIELD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one ASCII character per transfer
interface sidu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sidu_datapath.sv
`default_nettype none

module sidu_datapath
  import sidu_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned NUM_DIGITS  = 20
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] value_in,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  output logic [7:0]                  character,
  output logic                        last
);

  localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIGITS + 1);

  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [3:0]             top_digit;

  // Magnitude as unsigned; the most negative value maps onto itself
  assign mag_in = value_in[VALUE_WIDTH-1]
                  ? (~value_in + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_in;

  assign top_digit = bcd[BCD_W-1 -: 4];

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                   : bcd[4*i +: 4];
    end
  end

  // Conversion and digit shift registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value_in[VALUE_WIDTH-1];
      bin     <= mag_in;
      bcd     <= '0;
      bit_cnt <= BIT_CNT_W'(VALUE_WIDTH);
      dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
    end else if (cmd.conv_step) begin
      bcd     <= {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
      bin     <= {bin[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt - 1'b1;
    end else if (cmd.digit_shift) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - 1'b1;
    end
  end

  // Output character register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        SEL_MINUS: character <= CH_MINUS;
        SEL_DIGIT: character <= CH_ZERO | {4'd0, top_digit};
        SEL_CR:    character <= CH_CR;
        SEL_LF:    character <= CH_LF;
        default:   character <= CH_LF;
      endcase
      last <= (cmd.sel == SEL_LF);
    end
  end

  assign status.neg      = neg;
  assign status.bit_last = (bit_cnt == BIT_CNT_W'(1));
  assign status.dig_last = (dig_cnt == DIG_CNT_W'(1));
  assign status.top_zero = (top_digit == 4'd0);

endmodule

`default_nettype wire

FILE: hw/rtl/sidu_controller.sv
`default_nettype none

module sidu_controller
  import sidu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT,
    ST_CR,
    ST_LF
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   emitting;

  // Output register can take a character this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Commands and next state
  always_comb begin
    cmd        = '{load: 1'b0, conv_step: 1'b0, digit_shift: 1'b0, emit: 1'b0,
                   sel: SEL_DIGIT};
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.bit_last) begin
          state_next = status.neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        cmd.sel = SEL_MINUS;
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, always keeping the final digit
        if (status.top_zero && !status.dig_last) begin
          cmd.digit_shift = 1'b1;
        end else begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd.sel = SEL_DIGIT;
        if (slot_free) begin
          cmd.emit        = 1'b1;
          cmd.digit_shift = 1'b1;
          if (status.dig_last) begin
            state_next = ST_CR;
          end
        end
      end
      ST_CR: begin
        cmd.sel = SEL_CR;
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_LF;
        end
      end
      ST_LF: begin
        cmd.sel = SEL_LF;
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign emitting = cmd.emit;

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emitting) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
`default_nettype none

// Prints one signed value per input transfer as decimal ASCII text, most
// significant digit first: a minus sign for negative values, the digits with
// leading zeros dropped (zero prints as a single '0'), then CR and LF, with
// last set on the LF. Only the low VALUE_WIDTH bits of value are used, read
// as two's complement; the most negative value prints its exact magnitude.
// One value is handled at a time. A value is accepted, converted MSB first
// by the bit-serial shift-and-add-3 binary to BCD converter, which takes one
// input bit per cycle, then its leading zeros are dropped one digit at a
// time and its characters are sent, one per cycle when the output is not
// stalled. Dropped zeros and printed digits always fill every BCD digit
// position. The next value is accepted while the closing LF still waits in
// the output register.

module signed_int_to_decimal_ascii_unit
  import sidu_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sidu_in_if.sink  item,
  sidu_out_if.source result
);

  // Decimal digits that cover 2^(VALUE_WIDTH-1)
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;

  cmd_t    cmd;
  status_t status;

  sidu_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sidu_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dp (
    .clk       (clk),
    .value_in  (item.value[VALUE_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .character (result.character),
    .last      (result.last)
  );

endmodule

`default_nettype wire
